@@ rtl/aspv_pkg.sv @@
// shared constants, codes and controller/datapath interface types
// for the aspa path verifier; no dependencies
package aspv_pkg;

  localparam int TABLE_DEPTH_DEF = 256;
  localparam int AS_W            = 32;
  localparam int SRC_W           = 2;
  localparam int VERDICT_W       = 2;
  localparam int IN_TDATA_W      = 104;
  localparam int OUT_TDATA_W     = 8;

  localparam logic [VERDICT_W-1:0] VERDICT_VALID   = 2'd0;
  localparam logic [VERDICT_W-1:0] VERDICT_UNKNOWN = 2'd1;
  localparam logic [VERDICT_W-1:0] VERDICT_INVALID = 2'd2;

  localparam logic [SRC_W-1:0] SRC_CUSTOMER = 2'd0;
  localparam logic [SRC_W-1:0] SRC_PEER     = 2'd1;
  localparam logic [SRC_W-1:0] SRC_PROVIDER = 2'd2;
  localparam logic [SRC_W-1:0] SRC_UNDEF    = 2'd3;

  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_HOP  = 1'b1;

  // commands from controller to datapath
  typedef struct packed {
    logic load;
    logic capture;
    logic srch_start;
    logic srch_rev;
    logic set_inv;
    logic set_down;
    logic merge;
    logic finish;
  } aspv_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic                 first_pending;
    logic                 run_invalid;
    logic                 downward;
    logic                 src_provider;
    logic                 srch_busy;
    logic [VERDICT_W-1:0] srch_verdict;
    logic                 last;
    logic                 out_blocked;
  } aspv_sts_t;

endpackage

@@ rtl/aspa_path_verifier_core.sv @@
// top level of the aspa path verifier: stream ports, controller and datapath
// depends on aspv_pkg, aspv_ctrl, aspv_datapath (and through it aspv_ram)

// The block holds a table of up to TABLE_DEPTH customer-to-provider AS pairs
// and checks AS paths against it one hop per input transaction. A transaction
// with in_tuser low loads one pair into the next free slot (loads into a
// full table are dropped); with in_tuser high it is one hop, origin first,
// and in_tlast marks the final hop. Each hop after the first is checked by
// a linear scan of the loaded pairs through the single read port of the
// table RAM, one entry per cycle; when a provider route turns downward the
// same pair is searched again reversed. First hops and hops of an already
// failed path need no scan. Exactly one verdict leaves on the out channel
// per path, after its final hop: 0 valid, 1 unknown, 2 invalid. The verdict
// waits in an output register, so the next transaction is taken while it is
// still pending. The table needs no clearing after reset.
module aspa_path_verifier_core #(
  parameter int TABLE_DEPTH = aspv_pkg::TABLE_DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // input channel
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // tdata: hop asn[31:0], provider_as[63:32], path_source[65:64],
  //        neighbour asn[97:66], zero fill[103:98]
  input  logic [aspv_pkg::IN_TDATA_W-1:0]  in_tdata,
  // tuser: mode (0 load pair, 1 path hop)
  input  logic                             in_tuser,
  // tlast: last_hop
  input  logic                             in_tlast,
  // result channel
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // tdata: verdict[1:0], zero fill[7:2]
  output logic [aspv_pkg::OUT_TDATA_W-1:0] out_tdata
);

  aspv_pkg::aspv_cmd_t            cmd;
  aspv_pkg::aspv_sts_t            sts;
  logic                           in_accept;
  logic [aspv_pkg::VERDICT_W-1:0] verdict;

  // a transaction is taken when valid meets ready
  assign in_accept = in_tvalid && in_tready;

  aspv_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_accept (in_accept),
    .in_mode   (in_tuser),
    .in_ready  (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // unpack the hop / pair fields straight from tdata
  aspv_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_hop_asn     (in_tdata[31:0]),
    .in_provider_as (in_tdata[63:32]),
    .in_path_source (in_tdata[65:64]),
    .in_nbr_asn     (in_tdata[97:66]),
    .in_last_hop    (in_tlast),
    .out_ready      (out_tready),
    .out_valid      (out_tvalid),
    .out_verdict    (verdict)
  );

  assign out_tdata = {{(aspv_pkg::OUT_TDATA_W - aspv_pkg::VERDICT_W){1'b0}}, verdict};

  // the input side is closed while a table scan runs
  a_no_accept_during_search : assert property (
    @(posedge clk) disable iff (!rst_n)
    sts.srch_busy |-> !in_tready
  ) else $error("input ready while table search in progress");

  // a pair load only happens on an accepted load transaction
  a_load_on_accept : assert property (
    @(posedge clk) disable iff (!rst_n)
    cmd.load |-> (in_accept && (in_tuser == aspv_pkg::MODE_LOAD))
  ) else $error("table write without an accepted load");

  // after taking a hop the block is busy on the next cycle
  a_hop_busy : assert property (
    @(posedge clk) disable iff (!rst_n)
    cmd.capture |=> !in_tready
  ) else $error("hop accepted but block ready again at once");

  // a verdict is only written once the previous one has been taken
  a_no_overwrite : assert property (
    @(posedge clk) disable iff (!rst_n)
    (cmd.finish && sts.last) |-> !sts.out_blocked
  ) else $error("pending verdict overwritten");

endmodule

@@ rtl/aspv_ram.sv @@
// generic simple dual-port ram with registered read
// no dependencies
module aspv_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 256
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic                                    re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/aspv_ctrl.sv @@
// controller state machine: sequences load, search and verdict steps
// depends on aspv_pkg
module aspv_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_accept,
  input  logic              in_mode,
  output logic              in_ready,
  input  aspv_pkg::aspv_sts_t sts,
  output aspv_pkg::aspv_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_SEARCH1,
    S_SEARCH2,
    S_FINISH
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          if (in_mode == aspv_pkg::MODE_LOAD) begin
            cmd.load = 1'b1;
          end else begin
            cmd.capture = 1'b1;
            state_nxt   = S_DECIDE;
          end
        end
      end
      S_DECIDE: begin
        // first hop or failed path: nothing to check
        if (sts.first_pending || sts.run_invalid) begin
          state_nxt = S_FINISH;
        end else begin
          cmd.srch_start = 1'b1;
          cmd.srch_rev   = sts.downward;
          state_nxt      = S_SEARCH1;
        end
      end
      S_SEARCH1: begin
        if (!sts.srch_busy) begin
          if (sts.downward) begin
            cmd.merge = 1'b1;
            state_nxt = S_FINISH;
          end else if (sts.srch_verdict == aspv_pkg::VERDICT_INVALID) begin
            if (sts.src_provider) begin
              // switch to downward and recheck the same pair reversed
              cmd.set_down   = 1'b1;
              cmd.srch_start = 1'b1;
              cmd.srch_rev   = 1'b1;
              state_nxt      = S_SEARCH2;
            end else begin
              cmd.set_inv = 1'b1;
              state_nxt   = S_FINISH;
            end
          end else begin
            cmd.merge = 1'b1;
            state_nxt = S_FINISH;
          end
        end
      end
      S_SEARCH2: begin
        if (!sts.srch_busy) begin
          cmd.merge = 1'b1;
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        if (!(sts.last && sts.out_blocked)) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

@@ rtl/aspv_datapath.sv @@
// datapath: pair table, linear search unit, path state and result register
// depends on aspv_pkg and aspv_ram
module aspv_datapath #(
  parameter int TABLE_DEPTH = aspv_pkg::TABLE_DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  aspv_pkg::aspv_cmd_t              cmd,
  output aspv_pkg::aspv_sts_t              sts,
  input  logic [aspv_pkg::AS_W-1:0]        in_hop_asn,
  input  logic [aspv_pkg::AS_W-1:0]        in_provider_as,
  input  logic [aspv_pkg::SRC_W-1:0]       in_path_source,
  input  logic [aspv_pkg::AS_W-1:0]        in_nbr_asn,
  input  logic                             in_last_hop,
  input  logic                             out_ready,
  output logic                             out_valid,
  output logic [aspv_pkg::VERDICT_W-1:0]   out_verdict
);

  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int AS_W = aspv_pkg::AS_W;

  // pair table and fill count
  logic [CW-1:0]     count_r;
  logic              tbl_we;
  logic [2*AS_W-1:0] tbl_rdata;

  // captured hop
  logic [AS_W-1:0]              asn_r;
  logic [AS_W-1:0]              nbr_r;
  logic [aspv_pkg::SRC_W-1:0]   src_r;
  logic                         last_r;

  // path state
  logic [AS_W-1:0]                 prev_r;
  logic                            first_r;
  logic                            down_r;
  logic [aspv_pkg::VERDICT_W-1:0]  run_r;

  // search unit
  logic [CW-1:0]   idx_r;
  logic            issue_r;
  logic            rvld_r;
  logic            seen_r;
  logic            hit_r;
  logic [AS_W-1:0] cust_key_r;
  logic [AS_W-1:0] prov_key_r;
  logic            cust_match;
  logic [aspv_pkg::VERDICT_W-1:0] srch_verdict;

  // result register
  logic                           out_valid_r;
  logic [aspv_pkg::VERDICT_W-1:0] out_verdict_r;

  assign tbl_we = cmd.load && (count_r != CW'(TABLE_DEPTH));

  aspv_ram #(
    .WIDTH (2 * AS_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (count_r[AW-1:0]),
    .wdata ({in_provider_as, in_hop_asn}),
    .re    (issue_r),
    .raddr (idx_r[AW-1:0]),
    .rdata (tbl_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (tbl_we) begin
      count_r <= count_r + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      asn_r  <= in_hop_asn;
      nbr_r  <= in_nbr_asn;
      src_r  <= in_path_source;
      last_r <= in_last_hop;
    end
  end

  // one table read per cycle, compare on the following cycle
  assign cust_match = (tbl_rdata[AS_W-1:0] == cust_key_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      issue_r <= 1'b0;
      rvld_r  <= 1'b0;
    end else begin
      rvld_r <= issue_r;
      if (cmd.srch_start) begin
        issue_r <= (count_r != '0);
      end else if (issue_r && ((idx_r + CW'(1)) == count_r)) begin
        issue_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.srch_start) begin
      idx_r      <= '0;
      seen_r     <= 1'b0;
      hit_r      <= 1'b0;
      cust_key_r <= cmd.srch_rev ? asn_r : prev_r;
      prov_key_r <= cmd.srch_rev ? prev_r : asn_r;
    end else begin
      if (issue_r) begin
        idx_r <= idx_r + CW'(1);
      end
      if (rvld_r && cust_match) begin
        seen_r <= 1'b1;
        if (tbl_rdata[2*AS_W-1:AS_W] == prov_key_r) begin
          hit_r <= 1'b1;
        end
      end
    end
  end

  assign srch_verdict = hit_r  ? aspv_pkg::VERDICT_VALID   :
                        seen_r ? aspv_pkg::VERDICT_INVALID :
                                 aspv_pkg::VERDICT_UNKNOWN;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r  <= '0;
      first_r <= 1'b1;
      down_r  <= 1'b0;
      run_r   <= aspv_pkg::VERDICT_VALID;
    end else begin
      if (cmd.set_down) begin
        down_r <= 1'b1;
      end
      if (cmd.set_inv) begin
        run_r <= aspv_pkg::VERDICT_INVALID;
      end else if (cmd.merge && (srch_verdict > run_r)) begin
        run_r <= srch_verdict;
      end
      if (cmd.finish) begin
        if (last_r) begin
          prev_r  <= '0;
          first_r <= 1'b1;
          down_r  <= 1'b0;
          run_r   <= aspv_pkg::VERDICT_VALID;
        end else begin
          prev_r  <= asn_r;
          first_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.finish && last_r) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish && last_r) begin
      out_verdict_r <= (asn_r != nbr_r) ? aspv_pkg::VERDICT_INVALID : run_r;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_verdict = out_verdict_r;

  assign sts.first_pending = first_r;
  assign sts.run_invalid   = (run_r == aspv_pkg::VERDICT_INVALID);
  assign sts.downward      = down_r;
  assign sts.src_provider  = (src_r == aspv_pkg::SRC_PROVIDER);
  assign sts.srch_busy     = issue_r || rvld_r;
  assign sts.srch_verdict  = srch_verdict;
  assign sts.last          = last_r;
  assign sts.out_blocked   = out_valid_r && !out_ready;

endmodule
